// ===== rtl/bcdec_pkg.sv =====
package bcdec_pkg;

  localparam int CodeLen = 16;
  localparam int SynW    = 8;

  // columns of the parity-check matrix, bit 7 holds row 0
  localparam logic [SynW-1:0] HCOL [CodeLen] = '{
    8'hB8, 8'h5F, 8'h2E, 8'h17, 8'hB3, 8'hE1, 8'hC8, 8'h65,
    8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01
  };

  typedef enum logic [1:0] {
    ST_CLEAN   = 2'd0,
    ST_SINGLE  = 2'd1,
    ST_PAIR    = 2'd2,
    ST_NOMATCH = 2'd3
  } status_e;

  // after syndrome stage
  typedef struct packed {
    logic [CodeLen-1:0] word;
    logic [SynW-1:0]    syndrome;
  } syn_t;

  // after match stage: per-row first pair masks
  typedef struct packed {
    logic [CodeLen-1:0]              word;
    logic [SynW-1:0]                 syndrome;
    logic [CodeLen-1:0]              single_mask;
    logic [CodeLen-1:0]              row_hit;
    logic [CodeLen-1:0][CodeLen-1:0] row_mask;
  } match_t;

  // final result
  typedef struct packed {
    logic [CodeLen-1:0] corrected;
    logic [SynW-1:0]    syndrome;
    logic [CodeLen-1:0] mask;
    status_e            status;
  } res_t;

endpackage

// ===== rtl/bcdec_syn.sv =====
module bcdec_syn (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  logic [bcdec_pkg::CodeLen-1:0] word_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output bcdec_pkg::syn_t             data_o
);
  import bcdec_pkg::*;

  logic   valid_q;
  syn_t   data_q, data_d;

  // syndrome as xor of selected columns
  always_comb begin
    data_d.word     = word_i;
    data_d.syndrome = '0;
    for (int c = 0; c < CodeLen; c++) begin
      if (word_i[CodeLen-1-c]) data_d.syndrome = data_d.syndrome ^ HCOL[c];
    end
  end

  assign stall_o = valid_q && stall_i;

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/bcdec_match.sv =====
module bcdec_match (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  bcdec_pkg::syn_t   data_i,
  output logic              valid_o,
  input  logic              stall_i,
  output bcdec_pkg::match_t data_o
);
  import bcdec_pkg::*;

  logic   valid_q;
  match_t data_q, data_d;

  // single column compares and first partner per row
  always_comb begin
    data_d.word        = data_i.word;
    data_d.syndrome    = data_i.syndrome;
    data_d.single_mask = '0;
    data_d.row_hit     = '0;
    data_d.row_mask    = '0;
    for (int a = 0; a < CodeLen; a++) begin
      data_d.single_mask[CodeLen-1-a] = (HCOL[a] == data_i.syndrome);
      // scan downward so the lowest partner wins
      for (int b = CodeLen-1; b >= 0; b--) begin
        if (b > a && ((HCOL[a] ^ HCOL[b]) == data_i.syndrome)) begin
          data_d.row_hit[a]  = 1'b1;
          data_d.row_mask[a] = '0;
          data_d.row_mask[a][CodeLen-1-a] = 1'b1;
          data_d.row_mask[a][CodeLen-1-b] = 1'b1;
        end
      end
    end
  end

  assign stall_o = valid_q && stall_i;

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/bcdec_sel.sv =====
module bcdec_sel (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  bcdec_pkg::match_t data_i,
  output logic              valid_o,
  input  logic              stall_i,
  output bcdec_pkg::res_t   data_o
);
  import bcdec_pkg::*;

  logic               valid_q;
  res_t               data_q, data_d;
  logic [CodeLen-1:0] pair_mask;
  logic               pair_found;

  // first row with a matching pair
  always_comb begin
    pair_mask = '0;
    for (int a = CodeLen-1; a >= 0; a--) begin
      if (data_i.row_hit[a]) pair_mask = data_i.row_mask[a];
    end
    pair_found = |data_i.row_hit;
  end

  // combine masks, correct, classify
  always_comb begin
    data_d.syndrome  = data_i.syndrome;
    data_d.mask      = data_i.single_mask | pair_mask;
    data_d.corrected = data_i.word ^ data_d.mask;
    priority if (data_i.syndrome == '0) begin
      data_d.status = ST_CLEAN;
    end else if (pair_found) begin
      data_d.status = ST_PAIR;
    end else if (|data_i.single_mask) begin
      data_d.status = ST_SINGLE;
    end else begin
      data_d.status = ST_NOMATCH;
    end
  end

  assign stall_o = valid_q && stall_i;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/block_code_16_8_double_error_corrector_unit.sv =====
// (16,8) double error correcting decoder, three register stages:
// syndrome, column and pair compares, pair select with correction.
// throughput: one codeword per cycle unless stalled; a stall holds each full stage back to the first empty one
// reset: rst_ni low clears all stage valid bits, no payload reset
module block_code_16_8_double_error_corrector_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bcdec_pkg::CodeLen-1:0] received_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bcdec_pkg::CodeLen-1:0] corrected_word_o,
  output logic [7:0]                    data_byte_o,
  output logic [bcdec_pkg::SynW-1:0]    syndrome_o,
  output logic [bcdec_pkg::CodeLen-1:0] correction_mask_o,
  output logic [1:0]                    status_o
);
  import bcdec_pkg::*;

  logic   syn_valid, syn_stall;
  logic   match_valid, match_stall;
  syn_t   syn_data;
  match_t match_data;
  res_t   res_data;

  bcdec_syn u_syn (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .word_i  (received_word_i),
    .valid_o (syn_valid),
    .stall_i (syn_stall),
    .data_o  (syn_data)
  );

  bcdec_match u_match (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (syn_valid),
    .stall_o (syn_stall),
    .data_i  (syn_data),
    .valid_o (match_valid),
    .stall_i (match_stall),
    .data_o  (match_data)
  );

  bcdec_sel u_sel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (match_valid),
    .stall_o (match_stall),
    .data_i  (match_data),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (res_data)
  );

  // result fields
  assign corrected_word_o  = res_data.corrected;
  assign data_byte_o       = res_data.corrected[CodeLen-1 -: 8];
  assign syndrome_o        = res_data.syndrome;
  assign correction_mask_o = res_data.mask;
  assign status_o          = res_data.status;

endmodule

// ===== rtl/bcdec_checker.sv =====
module bcdec_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] corrected_word_o,
  input logic [7:0]  data_byte_o,
  input logic [7:0]  syndrome_o,
  input logic [15:0] correction_mask_o,
  input logic [1:0]  status_o
);
  import bcdec_pkg::*;

  // a stalled result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(corrected_word_o)
      && $stable(status_o))
    else $error("stalled result changed");

  // data byte follows corrected word
  a_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> data_byte_o == corrected_word_o[15:8])
    else $error("data byte mismatch");

  // clean word gets no correction
  a_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_CLEAN |-> syndrome_o == 8'h00
      && correction_mask_o == 16'h0000)
    else $error("clean status with correction");

  // unmatched syndrome leaves the word alone
  a_nomatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_NOMATCH |-> syndrome_o != 8'h00
      && correction_mask_o == 16'h0000)
    else $error("unmatched status with correction");

  // pair status flips at least two bits
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_PAIR |-> $countones(correction_mask_o) >= 2)
    else $error("pair status with short mask");

endmodule

bind block_code_16_8_double_error_corrector_unit bcdec_checker u_bcdec_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .corrected_word_o  (corrected_word_o),
  .data_byte_o       (data_byte_o),
  .syndrome_o        (syndrome_o),
  .correction_mask_o (correction_mask_o),
  .status_o          (status_o)
);
